@@ hdl/api_tx_frame_builder_macros.svh @@
// assertion macros used by the frame builder checker
// no dependencies; included by files that hold concurrent assertions
`ifndef API_TX_FRAME_BUILDER_MACROS_SVH
`define API_TX_FRAME_BUILDER_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ATFB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression that must never be true outside reset
`define ATFB_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

@@ hdl/atfb_pkg.sv @@
// shared constants and types for the api transmit frame builder
// no dependencies; used by atfb_framer and api_tx_frame_builder
package atfb_pkg;

    // frame layout constants
    localparam logic [7:0] DELIM         = 8'h7E;
    localparam logic [7:0] API_ID        = 8'h01;
    localparam int         LEN_OVERHEAD  = 5;
    localparam logic [6:0] MAX_PAYLOAD   = 7'd100;
    localparam logic [7:0] CHECK_INIT    = 8'hFF;
    localparam logic [7:0] FRAME_ID_INIT = 8'd1;
    localparam logic [7:0] FRAME_ID_MAX  = 8'd255;

    // configuration register reset values
    localparam logic [15:0] DEST_RESET = 16'h0066;
    localparam logic [7:0]  OPT_RESET  = 8'h00;

    // configuration register indexes
    localparam int         CFG_IDX_W       = 2;
    localparam logic [1:0] CFG_DEST_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_TX_OPTIONS   = 2'd1;

    // result buffer sizing: a frame's first byte yields the header plus the data byte
    localparam int MAX_RESULTS = 9;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic       in_frame;
        logic [6:0] bytes_left;
        logic [7:0] running_check;
        logic [7:0] frame_id;
    } t_frame_state;

    typedef struct packed {
        logic [CNT_W-1:0]                 count;
        logic [MAX_RESULTS-1:0][7:0]      res_byte;
        logic [MAX_RESULTS-1:0]           res_end;
    } t_result_set;

endpackage

@@ hdl/atfb_framer.sv @@
// per-item frame logic: builds the result bytes and next state for one input item
// depends on atfb_pkg
module atfb_framer (
    input  atfb_pkg::t_frame_state i_state,
    input  logic [7:0]             i_data_byte,
    input  logic [6:0]             i_payload_length,
    input  logic [15:0]            i_dest_address,
    input  logic [7:0]             i_tx_options,
    output atfb_pkg::t_frame_state o_next_state,
    output atfb_pkg::t_result_set  o_results
);

    logic [6:0]  len_sat;
    logic [15:0] total;
    logic [7:0]  hdr_sum;
    logic [7:0]  hdr_check;
    logic [7:0]  data_check;
    logic [6:0]  left_dec;

    // clamp the sampled length into the legal payload range
    always_comb begin
        if (i_payload_length == 7'd0) begin
            len_sat = 7'd1;
        end else if (i_payload_length > atfb_pkg::MAX_PAYLOAD) begin
            len_sat = atfb_pkg::MAX_PAYLOAD;
        end else begin
            len_sat = i_payload_length;
        end
    end

    // length field and checksum arithmetic
    assign total      = 16'(len_sat) + 16'(atfb_pkg::LEN_OVERHEAD);
    assign hdr_sum    = atfb_pkg::API_ID + i_state.frame_id + i_dest_address[15:8]
                      + i_dest_address[7:0] + i_tx_options + i_data_byte;
    assign hdr_check  = atfb_pkg::CHECK_INIT - hdr_sum;
    assign data_check = i_state.running_check - i_data_byte;
    assign left_dec   = i_state.bytes_left - 7'd1;

    // result bytes and state update
    always_comb begin
        o_next_state = i_state;
        o_results    = '0;
        if (i_state.in_frame && (i_state.bytes_left == 7'd0)) begin
            // closing step: checksum alone, input fields ignored
            o_results.count       = atfb_pkg::CNT_W'(1);
            o_results.res_byte[0] = i_state.running_check;
            o_results.res_end[0]  = 1'b1;
            o_next_state.in_frame      = 1'b0;
            o_next_state.bytes_left    = 7'd0;
            o_next_state.running_check = atfb_pkg::CHECK_INIT;
        end else if (!i_state.in_frame) begin
            // first byte of a frame: full header then the data byte
            o_results.count       = atfb_pkg::CNT_W'(atfb_pkg::MAX_RESULTS);
            o_results.res_byte[0] = atfb_pkg::DELIM;
            o_results.res_byte[1] = total[15:8];
            o_results.res_byte[2] = total[7:0];
            o_results.res_byte[3] = atfb_pkg::API_ID;
            o_results.res_byte[4] = i_state.frame_id;
            o_results.res_byte[5] = i_dest_address[15:8];
            o_results.res_byte[6] = i_dest_address[7:0];
            o_results.res_byte[7] = i_tx_options;
            o_results.res_byte[8] = i_data_byte;
            o_next_state.in_frame      = 1'b1;
            o_next_state.bytes_left    = len_sat - 7'd1;
            o_next_state.running_check = hdr_check;
            o_next_state.frame_id      = (i_state.frame_id >= atfb_pkg::FRAME_ID_MAX)
                                       ? atfb_pkg::FRAME_ID_INIT
                                       : i_state.frame_id + 8'd1;
        end else begin
            // payload byte passes through, checksum follows the last one
            o_results.res_byte[0] = i_data_byte;
            if (left_dec == 7'd0) begin
                o_results.count       = atfb_pkg::CNT_W'(2);
                o_results.res_byte[1] = data_check;
                o_results.res_end[1]  = 1'b1;
                o_next_state.in_frame      = 1'b0;
                o_next_state.bytes_left    = 7'd0;
                o_next_state.running_check = atfb_pkg::CHECK_INIT;
            end else begin
                o_results.count            = atfb_pkg::CNT_W'(1);
                o_next_state.bytes_left    = left_dec;
                o_next_state.running_check = data_check;
            end
        end
    end

endmodule

@@ hdl/api_tx_frame_builder.sv @@
// top level of the api transmit frame builder: handshakes, state and result buffer
// depends on atfb_pkg and atfb_framer
//
// Payload bytes enter on the slave stream and leave, wrapped in a transmit-request
// frame with a trailing checksum, on the master stream at one byte per cycle while the
// sink is ready. The output port sets the rate: the first byte of a frame expands to 9
// output bytes (delimiter, length, api id, frame id, address, options, data), a middle
// byte to 1 byte and the last byte to 2 (data then checksum); a one-byte frame sends
// its checksum on the next item, whose fields are ignored. A new item is taken in the
// same cycle as the last buffered byte leaves, so a sink that never stalls sees no
// gaps. Configuration writes are always accepted and apply from the next frame header.
module api_tx_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] data_byte, [14:8] payload_length, [15] zero
    // output byte stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic        o_m_axis_tlast,   // frame_end
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [atfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    atfb_pkg::t_frame_state r_state;
    atfb_pkg::t_frame_state n_state;
    atfb_pkg::t_result_set  step_res;

    logic [15:0] r_dest_address;
    logic [7:0]  r_tx_options;

    logic [atfb_pkg::MAX_RESULTS-1:0][7:0] r_buf_byte;
    logic [atfb_pkg::MAX_RESULTS-1:0][7:0] n_buf_byte;
    logic [atfb_pkg::MAX_RESULTS-1:0]      r_buf_end;
    logic [atfb_pkg::MAX_RESULTS-1:0]      n_buf_end;
    logic [atfb_pkg::CNT_W-1:0]            r_cnt;
    logic [atfb_pkg::CNT_W-1:0]            n_cnt;

    logic in_take;
    logic out_take;

    // handshakes
    assign out_take        = o_m_axis_tvalid && i_m_axis_tready;
    assign o_s_axis_tready = (r_cnt == '0)
                          || ((r_cnt == atfb_pkg::CNT_W'(1)) && i_m_axis_tready);
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // per-item frame logic
    atfb_framer u_framer (
        .i_state          (r_state),
        .i_data_byte      (i_s_axis_tdata[7:0]),
        .i_payload_length (i_s_axis_tdata[14:8]),
        .i_dest_address   (r_dest_address),
        .i_tx_options     (r_tx_options),
        .o_next_state     (n_state),
        .o_results        (step_res)
    );

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.in_frame      <= 1'b0;
            r_state.bytes_left    <= 7'd0;
            r_state.running_check <= atfb_pkg::CHECK_INIT;
            r_state.frame_id      <= atfb_pkg::FRAME_ID_INIT;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_address <= atfb_pkg::DEST_RESET;
            r_tx_options   <= atfb_pkg::OPT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                atfb_pkg::CFG_DEST_ADDRESS: r_dest_address <= i_cfg_data;
                atfb_pkg::CFG_TX_OPTIONS:   r_tx_options   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // result buffer: load a fresh set or shift one byte out
    always_comb begin
        n_buf_byte = r_buf_byte;
        n_buf_end  = r_buf_end;
        n_cnt      = r_cnt;
        if (in_take) begin
            n_buf_byte = step_res.res_byte;
            n_buf_end  = step_res.res_end;
            n_cnt      = step_res.count;
        end else if (out_take) begin
            n_buf_byte = {8'h00, r_buf_byte[atfb_pkg::MAX_RESULTS-1:1]};
            n_buf_end  = {1'b0, r_buf_end[atfb_pkg::MAX_RESULTS-1:1]};
            n_cnt      = r_cnt - atfb_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf_byte <= n_buf_byte;
        r_buf_end  <= n_buf_end;
    end

    // output stream
    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = r_buf_byte[0];
    assign o_m_axis_tlast  = r_buf_end[0];

endmodule

@@ hdl/atfb_checker.sv @@
// port-level checks of the api transmit frame builder, bound to the top level
// depends on api_tx_frame_builder_macros.svh and api_tx_frame_builder
`include "api_tx_frame_builder_macros.svh"

module atfb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [15:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [15:0] i_cfg_data
);

    // an empty output side always takes input
    `ATFB_NEVER(a_idle_ready, i_clk, i_rst_n, !o_m_axis_tvalid && !o_s_axis_tready, "block idle but not ready")

    // every accepted item yields at least one byte in the next cycle
    `ATFB_ASSERT(a_item_yields, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready) |=> o_m_axis_tvalid, "accepted item produced no output")

    // a stalled output byte holds
    `ATFB_ASSERT(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)), "stalled output changed")

    // input is never made ready while a buffered output byte is stalled
    `ATFB_ASSERT(a_no_overrun, i_clk, i_rst_n, (o_s_axis_tready && o_m_axis_tvalid) |-> i_m_axis_tready, "input taken while output stalled")

endmodule

bind api_tx_frame_builder atfb_checker u_atfb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .i_cfg_valid     (i_cfg_valid),
    .o_cfg_ready     (o_cfg_ready),
    .i_cfg_index     (i_cfg_index),
    .i_cfg_data      (i_cfg_data)
);
